FILE: design/vca_pkg.sv
// Shared types and constants for the voice channel allocator.
`timescale 1ns / 1ps
`default_nettype none

package vca_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CFG_W        = 4;
  localparam int TIME_W       = 16;
  localparam int CHAN_W       = 3;
  localparam int MASK_W       = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  localparam logic MODE_PLAY = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_AGE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] sound_duration;
    logic [TIME_W-1:0] elapsed_ms;
  } req_item_t;

  typedef struct packed {
    logic              accepted;
    logic [CHAN_W-1:0] channel;
    logic              stolen;
    logic [MASK_W-1:0] live_mask;
  } rsp_item_t;

  typedef struct packed {
    logic              live;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] duration;
  } voice_t;

endpackage

`default_nettype wire

FILE: design/vca_chan_if.sv
// Valid/ready channel interface carrying one item type.
`timescale 1ns / 1ps
`default_nettype none

interface vca_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/voice_channel_allocator.sv
// Top level: voice pool with first-free allocation and ratio-based stealing.
//
//   port      dir  payload                                   accepted when
//   req_i     in   mode, sound_duration, elapsed_ms          req_i.valid && req_i.ready
//   rsp_o     out  accepted, channel, stolen, live_mask      rsp_o.valid && rsp_o.ready
//   cfg_we_i  in   cfg_wdata_i = channels_in_use             cfg_we_i high
//
// A play result is loaded into the result register in the done state, after one scan
// rotation and one write rotation; a tick result after one age rotation. The next item
// is taken in idle, once the result is loaded. Each rotation moves
// the voice records one cell per cycle past the single shared compare/multiply head.
// Reset clears every voice and sets channels_in_use to 8; no clearing pass.
// A finished item waits in the result register; a new item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module voice_channel_allocator #(
  parameter int CHANNELS = vca_pkg::CHANNELS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [vca_pkg::CFG_W-1:0] cfg_wdata_i,
  vca_chan_if.sink                       req_i,
  vca_chan_if.source                     rsp_o
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [vca_pkg::CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] n_eff;
  logic [vca_pkg::MASK_W-1:0] live_mask;
  logic shift;
  vca_pkg::voice_t head_in;
  vca_pkg::voice_t head_out;
  vca_pkg::voice_t cell_out [CHANNELS];
  vca_pkg::voice_t cell_in  [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vca_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (32'(cfg_q) >= 32'(CHANNELS)) begin
      n_eff = CNT_W'(CHANNELS);
    end else begin
      n_eff = CNT_W'(cfg_q);
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    if (i == CHANNELS - 1) begin : g_tail
      assign cell_in[i] = head_out;
    end else begin : g_link
      assign cell_in[i] = cell_out[i+1];
    end

    vca_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .voice_i (cell_in[i]),
      .voice_o (cell_out[i])
    );
  end

  assign head_in = cell_out[0];

  for (genvar b = 0; b < vca_pkg::MASK_W; b++) begin : g_mask
    if (b < CHANNELS) begin : g_used
      assign live_mask[b] = cell_out[b].live;
    end else begin : g_unused
      assign live_mask[b] = 1'b0;
    end
  end

  vca_ctrl #(
    .CHANNELS (CHANNELS),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .n_i         (n_eff),
    .live_mask_i (live_mask),
    .head_i      (head_in),
    .head_o      (head_out),
    .shift_o     (shift)
  );

endmodule

`default_nettype wire

FILE: design/vca_cell.sv
// One voice cell of the rotating channel chain.
`timescale 1ns / 1ps
`default_nettype none

module vca_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire vca_pkg::voice_t voice_i,
  output vca_pkg::voice_t      voice_o
);

  vca_pkg::voice_t voice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else if (shift_i) begin
      voice_q <= voice_i;
    end
  end

  assign voice_o = voice_q;

endmodule

`default_nettype wire

FILE: design/vca_ctrl.sv
// Sequencer and shared head unit: scan, write back and age voices as they rotate.
`timescale 1ns / 1ps
`default_nettype none

module vca_ctrl #(
  parameter int CHANNELS = vca_pkg::CHANNELS_DEF,
  parameter int CNT_W    = $clog2(CHANNELS + 1),
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  vca_chan_if.sink                        req_i,
  vca_chan_if.source                      rsp_o,
  input  wire logic [CNT_W-1:0]           n_i,
  input  wire logic [vca_pkg::MASK_W-1:0] live_mask_i,
  input  wire vca_pkg::voice_t            head_i,
  output vca_pkg::voice_t                 head_o,
  output logic                            shift_o
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(CHANNELS - 1);

  vca_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic mode_q, mode_d;
  logic [vca_pkg::TIME_W-1:0] arg_q, arg_d;
  logic found_q, found_d;
  logic [IDX_W-1:0] free_q, free_d;
  logic [IDX_W-1:0] best_q, best_d;
  logic [vca_pkg::TIME_W-1:0] best_rem_q, best_rem_d;
  logic [vca_pkg::TIME_W-1:0] best_dur_q, best_dur_d;
  logic out_valid_q, out_valid_d;
  vca_pkg::rsp_item_t out_q, out_d;

  logic [2*vca_pkg::TIME_W-1:0] prod_a;
  logic [2*vca_pkg::TIME_W-1:0] prod_b;
  logic [IDX_W-1:0] pick;
  logic [IDX_W+vca_pkg::CHAN_W-1:0] pick_ext;
  logic in_range;
  logic last_step;
  logic grant;

  assign prod_a    = head_i.remaining * best_dur_q;
  assign prod_b    = best_rem_q * head_i.duration;
  assign pick      = found_q ? free_q : best_q;
  assign pick_ext  = {{vca_pkg::CHAN_W{1'b0}}, pick};
  assign in_range  = k_q < n_i;
  assign last_step = k_q == LAST;
  assign grant     = (mode_q == vca_pkg::MODE_PLAY) && (n_i != '0);

  assign req_i.ready = state_q == vca_pkg::ST_IDLE;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    mode_d      = mode_q;
    arg_d       = arg_q;
    found_d     = found_q;
    free_d      = free_q;
    best_d      = best_q;
    best_rem_d  = best_rem_q;
    best_dur_d  = best_dur_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    head_o      = head_i;
    shift_o     = 1'b0;

    case (state_q)
      vca_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          mode_d  = req_i.data.mode;
          arg_d   = (req_i.data.mode == vca_pkg::MODE_TICK) ? req_i.data.elapsed_ms
                                                           : req_i.data.sound_duration;
          k_d     = '0;
          found_d = 1'b0;
          state_d = (req_i.data.mode == vca_pkg::MODE_TICK) ? vca_pkg::ST_AGE
                                                            : vca_pkg::ST_SCAN;
        end
      end
      vca_pkg::ST_SCAN: begin
        shift_o = 1'b1;
        if (in_range && !head_i.live && !found_q) begin
          found_d = 1'b1;
          free_d  = IDX_W'(k_q);
        end
        if (k_q == '0 || (in_range && (prod_a < prod_b))) begin
          best_d     = IDX_W'(k_q);
          best_rem_d = head_i.remaining;
          best_dur_d = head_i.duration;
        end
        k_d = k_q + CNT_W'(1);
        if (last_step) begin
          k_d     = '0;
          state_d = vca_pkg::ST_WRITE;
        end
      end
      vca_pkg::ST_WRITE: begin
        shift_o = 1'b1;
        if (grant && (k_q == CNT_W'(pick))) begin
          head_o.live      = 1'b1;
          head_o.remaining = arg_q;
          head_o.duration  = arg_q;
        end
        k_d = k_q + CNT_W'(1);
        if (last_step) begin
          k_d     = '0;
          state_d = vca_pkg::ST_DONE;
        end
      end
      vca_pkg::ST_AGE: begin
        shift_o = 1'b1;
        if (head_i.live) begin
          if (arg_q > head_i.remaining) begin
            head_o = '0;
          end else begin
            head_o.remaining = head_i.remaining - arg_q;
          end
        end
        k_d = k_q + CNT_W'(1);
        if (last_step) begin
          k_d     = '0;
          state_d = vca_pkg::ST_DONE;
        end
      end
      vca_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d       = 1'b1;
          out_d.accepted    = grant;
          out_d.channel     = grant ? pick_ext[vca_pkg::CHAN_W-1:0] : '0;
          out_d.stolen      = grant && !found_q;
          out_d.live_mask   = live_mask_i;
          state_d           = vca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vca_pkg::ST_IDLE;
      k_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    arg_q      <= arg_d;
    free_q     <= free_d;
    best_q     <= best_d;
    best_rem_q <= best_rem_d;
    best_dur_q <= best_dur_d;
    out_q      <= out_d;
  end

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= LAST)
    else $error("step counter beyond last channel");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("new item taken while one is in flight");

  a_steal_needs_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.stolen || out_q.accepted))
    else $error("steal reported without a granted channel");

  a_tick_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vca_pkg::ST_AGE) |-> !grant)
    else $error("tick item would grant a channel");

endmodule

`default_nettype wire
